/* src/jsu_pkg.sv */
package jsu_pkg;

    // Kind of a result word, carried on m_tuser.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Parser position inside a string.
    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_STR  = 3'd1,
        M_ESC  = 3'd2,
        M_HEX  = 3'd3,
        M_LBS  = 3'd4,
        M_LU   = 3'd5,
        M_LHEX = 3'd6,
        M_UTF  = 3'd7
    } mode_t;

    // All result words caused by one source byte. cnt is 0 when the byte
    // produces nothing; close and error groups always hold one word.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        kind_t           kind;
    } group_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [20:0] MAX_SCALAR = 21'h10ffff;
    localparam logic [15:0] HIGH_LO    = 16'hd800;
    localparam logic [15:0] HIGH_HI    = 16'hdbff;
    localparam logic [15:0] LOW_LO     = 16'hdc00;
    localparam logic [15:0] LOW_HI     = 16'hdfff;

    // Returns {valid, digit value} for one ASCII hex digit.
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // UTF-8 encoding of one scalar value as a byte group.
    function automatic group_t utf8_encode(logic [20:0] p);
        group_t g;
        g = '0;
        g.kind = KIND_BYTE;
        if (p <= 21'h7f) begin
            g.bytes[0] = p[7:0];
            g.cnt      = 3'd1;
        end else if (p <= 21'h7ff) begin
            g.bytes[0] = {3'b110, p[10:6]};
            g.bytes[1] = {2'b10, p[5:0]};
            g.cnt      = 3'd2;
        end else if (p <= 21'hffff) begin
            g.bytes[0] = {4'b1110, p[15:12]};
            g.bytes[1] = {2'b10, p[11:6]};
            g.bytes[2] = {2'b10, p[5:0]};
            g.cnt      = 3'd3;
        end else begin
            g.bytes[0] = {5'b11110, p[20:18]};
            g.bytes[1] = {2'b10, p[17:12]};
            g.bytes[2] = {2'b10, p[11:6]};
            g.bytes[3] = {2'b10, p[5:0]};
            g.cnt      = 3'd4;
        end
        return g;
    endfunction

endpackage

/* src/jsu_decode.sv */
module jsu_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            source_end,
    input  logic [15:0]     limit,
    output jsu_pkg::group_t grp
);
    import jsu_pkg::*;

    mode_t           mode_reg, mode_next;
    logic [15:0]     hex_accum_reg, hex_accum_next;
    logic [9:0]      high_half_reg, high_half_next;
    logic [2:0]      hex_seen_reg, hex_seen_next;
    logic [3:0][7:0] scalar_bytes_reg, scalar_bytes_next;
    logic [2:0]      scalar_width_reg, scalar_width_next;
    logic [2:0]      scalar_seen_reg, scalar_seen_next;
    logic [16:0]     length_reg, length_next;

    logic [4:0]      hv;
    logic [15:0]     acc_new;
    logic [2:0]      hex_seen_inc;
    logic [3:0][7:0] sb_new;
    logic [2:0]      seen_inc;

    assign hv           = hex_value(in_byte);
    assign acc_new      = {hex_accum_reg[11:0], hv[3:0]};
    assign hex_seen_inc = hex_seen_reg + 3'd1;
    assign seen_inc     = scalar_seen_reg + 3'd1;

    always_comb begin
        sb_new = scalar_bytes_reg;
        sb_new[scalar_seen_reg[1:0]] = in_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= M_IDLE;
            hex_accum_reg    <= '0;
            high_half_reg    <= '0;
            hex_seen_reg     <= '0;
            scalar_width_reg <= '0;
            scalar_seen_reg  <= '0;
            length_reg       <= '0;
        end else begin
            mode_reg         <= mode_next;
            hex_accum_reg    <= hex_accum_next;
            high_half_reg    <= high_half_next;
            hex_seen_reg     <= hex_seen_next;
            scalar_width_reg <= scalar_width_next;
            scalar_seen_reg  <= scalar_seen_next;
            length_reg       <= length_next;
        end
    end

    always_ff @(posedge aclk) begin
        scalar_bytes_reg <= scalar_bytes_next;
    end

    always_comb begin
        logic        emit;
        logic        err;
        logic        close;
        group_t      eg;
        logic [20:0] p;
        logic [20:0] pmin;
        logic [17:0] sum;

        mode_next         = mode_reg;
        hex_accum_next    = hex_accum_reg;
        high_half_next    = high_half_reg;
        hex_seen_next     = hex_seen_reg;
        scalar_bytes_next = scalar_bytes_reg;
        scalar_width_next = scalar_width_reg;
        scalar_seen_next  = scalar_seen_reg;
        length_next       = length_reg;
        emit  = 1'b0;
        err   = 1'b0;
        close = 1'b0;
        eg    = '0;
        eg.kind = KIND_BYTE;
        p     = '0;
        pmin  = '0;
        sum   = '0;
        grp   = '0;
        grp.kind = KIND_BYTE;

        if (step) begin
            if (mode_reg == M_IDLE) begin
                if (!source_end && in_byte == CH_QUOTE) begin
                    mode_next   = M_STR;
                    length_next = '0;
                end
            end else if (source_end) begin
                err = 1'b1;
            end else begin
                case (mode_reg)
                    M_STR: begin
                        if (in_byte == CH_QUOTE) begin
                            close = 1'b1;
                        end else if (in_byte < CH_SPACE) begin
                            err = 1'b1;
                        end else if (in_byte == CH_BSLASH) begin
                            mode_next = M_ESC;
                        end else if (!in_byte[7]) begin
                            emit         = 1'b1;
                            eg.bytes[0]  = in_byte;
                            eg.cnt       = 3'd1;
                        end else begin
                            if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
                                scalar_width_next = 3'd2;
                            end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
                                scalar_width_next = 3'd3;
                            end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
                                scalar_width_next = 3'd4;
                            end else begin
                                err = 1'b1;
                            end
                            if (!err) begin
                                scalar_bytes_next[0] = in_byte;
                                scalar_seen_next     = 3'd1;
                                mode_next            = M_UTF;
                            end
                        end
                    end
                    M_UTF: begin
                        if (in_byte[7:6] != 2'b10) begin
                            err = 1'b1;
                        end else begin
                            scalar_bytes_next = sb_new;
                            scalar_seen_next  = seen_inc;
                            if (seen_inc >= scalar_width_reg) begin
                                case (scalar_width_reg)
                                    3'd2: begin
                                        p    = {10'd0, sb_new[0][4:0], sb_new[1][5:0]};
                                        pmin = 21'h80;
                                        eg.cnt = 3'd2;
                                    end
                                    3'd3: begin
                                        p    = {5'd0, sb_new[0][3:0], sb_new[1][5:0],
                                                sb_new[2][5:0]};
                                        pmin = 21'h800;
                                        eg.cnt = 3'd3;
                                    end
                                    default: begin
                                        p    = {sb_new[0][2:0], sb_new[1][5:0],
                                                sb_new[2][5:0], sb_new[3][5:0]};
                                        pmin = 21'h10000;
                                        eg.cnt = 3'd4;
                                    end
                                endcase
                                if (p < pmin || p > MAX_SCALAR ||
                                    (p >= 21'(HIGH_LO) && p <= 21'(LOW_HI))) begin
                                    err = 1'b1;
                                end else begin
                                    mode_next = M_STR;
                                    emit      = 1'b1;
                                    eg.bytes  = sb_new;
                                end
                            end
                        end
                    end
                    M_ESC: begin
                        mode_next = M_STR;
                        eg.cnt    = 3'd1;
                        emit      = 1'b1;
                        case (in_byte)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: eg.bytes[0] = in_byte;
                            CH_B: eg.bytes[0] = 8'h08;
                            CH_F: eg.bytes[0] = 8'h0c;
                            CH_N: eg.bytes[0] = 8'h0a;
                            CH_R: eg.bytes[0] = 8'h0d;
                            CH_T: eg.bytes[0] = 8'h09;
                            CH_U: begin
                                emit           = 1'b0;
                                mode_next      = M_HEX;
                                hex_accum_next = '0;
                                hex_seen_next  = '0;
                            end
                            default: begin
                                emit = 1'b0;
                                err  = 1'b1;
                            end
                        endcase
                    end
                    M_HEX, M_LHEX: begin
                        if (!hv[4]) begin
                            err = 1'b1;
                        end else begin
                            hex_accum_next = acc_new;
                            hex_seen_next  = hex_seen_inc;
                            if (hex_seen_inc >= 3'd4) begin
                                if (mode_reg == M_HEX) begin
                                    if (acc_new >= HIGH_LO && acc_new <= HIGH_HI) begin
                                        high_half_next = acc_new[9:0];
                                        mode_next      = M_LBS;
                                    end else if (acc_new >= LOW_LO && acc_new <= LOW_HI) begin
                                        err = 1'b1;
                                    end else begin
                                        mode_next = M_STR;
                                        emit      = 1'b1;
                                        eg        = utf8_encode({5'd0, acc_new});
                                    end
                                end else if (acc_new < LOW_LO || acc_new > LOW_HI) begin
                                    err = 1'b1;
                                end else begin
                                    // Surrogate pair: 0x10000 plus 20 payload bits.
                                    mode_next = M_STR;
                                    emit      = 1'b1;
                                    eg        = utf8_encode(21'h10000 +
                                                {1'b0, high_half_reg, acc_new[9:0]});
                                end
                            end
                        end
                    end
                    M_LBS: begin
                        if (in_byte != CH_BSLASH) begin
                            err = 1'b1;
                        end else begin
                            mode_next = M_LU;
                        end
                    end
                    M_LU: begin
                        if (in_byte != CH_U) begin
                            err = 1'b1;
                        end else begin
                            mode_next      = M_LHEX;
                            hex_accum_next = '0;
                            hex_seen_next  = '0;
                        end
                    end
                    default: begin
                        err = 1'b1;
                    end
                endcase
            end

            if (emit) begin
                sum = {1'b0, length_reg} + 18'(eg.cnt);
                if (sum > 18'(limit)) begin
                    err = 1'b1;
                end else begin
                    length_next = sum[16:0];
                    grp         = eg;
                end
            end

            if (err) begin
                grp       = '0;
                grp.kind  = KIND_ERROR;
                grp.cnt   = 3'd1;
                mode_next = M_IDLE;
            end else if (close) begin
                grp       = '0;
                grp.kind  = KIND_CLOSE;
                grp.cnt   = 3'd1;
                mode_next = M_IDLE;
            end
        end
    end

endmodule

/* src/json_string_unescape.sv */
// JSON string unescaper with UTF-8 validation. Source bytes enter on the s_
// side starting at the opening quote; bytes before it are dropped silently.
// Decoded UTF-8 leaves on the m_ side one word per byte, tagged by m_tuser
// as a data byte, a string close, or an error, with m_tlast marking the final
// word caused by one source byte. Escapes \" \\ \/ \b \f \n \r \t and \uXXXX
// are decoded, surrogate pairs are joined, raw multi-byte UTF-8 is held back
// until the whole scalar has been checked, and a string whose decoded length
// would exceed the smaller of the cfg_data limit and MAX_STRING_BYTES ends
// in an error word instead of the offending scalar. A source byte is taken
// every cycle while the group queue has room: it is registered, decoded
// combinationally, and its words are queued in a two-entry group queue. The
// output side moves one word per cycle while m_tready is high, so a source
// byte that decodes to N bytes holds the output for N words (N is at most four).
// The limit register may be written only while no string is being processed.
module json_string_unescape #(
    parameter int unsigned MAX_STRING_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: largest decoded string length in bytes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Source stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] source_end: source exhausted, tdata ignored
    // Decoded stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind: 0 byte, 1 close, 2 error
    output logic        m_tlast    // final word caused by one source byte
);
    import jsu_pkg::*;

    localparam logic [15:0] LIMIT_CAP =
        (MAX_STRING_BYTES > 65535) ? 16'hffff : 16'(MAX_STRING_BYTES);

    logic [15:0] string_limit_reg;
    logic [15:0] limit_eff;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    group_t      grp_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  idx_reg;

    group_t      dec_grp;
    group_t      head;
    logic        consume;
    logic        push;
    logic        pop;
    logic        word_done;

    // The limit register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            string_limit_reg <= 16'hffff;
        end else if (cfg_valid) begin
            string_limit_reg <= cfg_data;
        end
    end

    assign limit_eff = (string_limit_reg < LIMIT_CAP) ? string_limit_reg : LIMIT_CAP;

    // The held byte is decoded once the group queue has a free entry.
    assign consume  = in_valid_reg && (cnt_reg != 2'd2);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    jsu_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (consume),
        .in_byte    (in_byte_reg),
        .source_end (in_end_reg),
        .limit      (limit_eff),
        .grp        (dec_grp)
    );

    // Group queue: source bytes that produce nothing are not queued.
    assign push = consume && (dec_grp.cnt != 3'd0);

    assign head      = grp_reg[rd_ptr_reg];
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_tdata   = head.bytes[idx_reg];
    assign m_tuser   = head.kind;
    assign m_tlast   = ({1'b0, idx_reg} + 3'd1) == head.cnt;
    assign word_done = m_tvalid && m_tready;
    assign pop       = word_done && m_tlast;

    always_ff @(posedge aclk) begin
        if (push) begin
            grp_reg[wr_ptr_reg] <= dec_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                idx_reg    <= 2'd0;
            end else if (word_done) begin
                idx_reg <= idx_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // The queue never holds more than its two entries.
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("group queue overflow");

    // Close and error words stand alone, so they always end their group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_BYTE) |-> m_tlast)
        else $error("close or error word not marked last");

    // A partly sent group keeps the queue non-empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> m_tvalid)
        else $error("word index set with empty queue");

    // A decoded group never carries more than four words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (dec_grp.cnt <= 3'd4))
        else $error("decoded group too large");

endmodule
